// ===== rtl/i2crm_pkg.sv =====
// i2crm_pkg: shared types, codes and reset values for the I2C register master.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package i2crm_pkg;

	// Command codes carried in the input beat's tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
	localparam logic [1:0] CFG_DELAY    = 2'd1;
	localparam logic [1:0] CFG_STRETCH  = 2'd2;

	// Configuration reset values
	localparam logic [6:0]  DEV_ADDR_RST = 7'd21;
	localparam logic [15:0] DELAY_RST    = 16'd30;
	localparam logic [15:0] STRETCH_RST  = 16'd500;

	// Bus phases: start, stop, send bit, send-side ack, read bit, read-side ack
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST0, PH_ST1, PH_ST2, PH_ST3,
		PH_SP0, PH_SP1, PH_SP2, PH_SP3,
		PH_SB0, PH_SB1, PH_SB2, PH_SB3,
		PH_SA0, PH_SA1, PH_SA2, PH_SA3,
		PH_RB0, PH_RB1, PH_RB2,
		PH_RK0, PH_RK1, PH_RK2, PH_RK3
	} phase_t;

	// Transaction stages
	typedef enum logic [2:0] {
		SG_START1, SG_ADDR_W, SG_REG, SG_START2,
		SG_ADDR_R, SG_DATA_W, SG_READ, SG_STOP
	} stage_t;

	typedef struct packed {
		logic [6:0]  dev_addr;
		logic [15:0] delay_ticks;
		logic [15:0] stretch_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic [7:0] read_len;
		logic       scl_in;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       last_byte;
		logic       done_res;
		logic       nack_error;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		stage_t      stage;
		logic [3:0]  bit_count;
		logic [7:0]  byte_count;
		logic [7:0]  shift_byte;
		logic [15:0] delay_count;
		logic [15:0] stretch_count;
		logic [7:0]  held_reg;
		logic [7:0]  held_data;
		logic [7:0]  held_len;
		logic        is_read;
		logic        scl_level;
		logic        sda_level;
		logic        error_flag;
	} state_t;

	localparam state_t STATE_RST = '{
		phase: PH_IDLE, stage: SG_START1, bit_count: 4'd0, byte_count: 8'd0,
		shift_byte: 8'd0, delay_count: 16'd0, stretch_count: 16'd0,
		held_reg: 8'd0, held_data: 8'd0, held_len: 8'd0, is_read: 1'b0,
		scl_level: 1'b1, sda_level: 1'b1, error_flag: 1'b0
	};

endpackage

// ===== rtl/i2crm_cfg.sv =====
// i2crm_cfg: configuration registers (device address, delay, stretch limit).
// Depends on i2crm_pkg.
`timescale 1ns / 1ps

module i2crm_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata,
	output i2crm_pkg::cfg_t   cfg
);
	import i2crm_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr      <= DEV_ADDR_RST;
			cfg_q.delay_ticks   <= DELAY_RST;
			cfg_q.stretch_limit <= STRETCH_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_DEV_ADDR: cfg_q.dev_addr      <= cfg_wdata[6:0];
				CFG_DELAY:    cfg_q.delay_ticks   <= cfg_wdata;
				CFG_STRETCH:  cfg_q.stretch_limit <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/i2crm_core.sv =====
// i2crm_core: bus sequencer state and the single-tick step logic.
// Each accepted beat advances the state by one tick and yields one result.
// Depends on i2crm_pkg.
`timescale 1ns / 1ps

module i2crm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  i2crm_pkg::tick_t    tick,
	input  i2crm_pkg::cfg_t     cfg,
	output i2crm_pkg::result_t  res
);
	import i2crm_pkg::*;

	state_t st_q;
	state_t nxt;
	logic   finished;
	logic   is_wait;
	logic [15:0] dmax;
	logic [15:0] dcnt_inc;

	// Phase entry: clear timers and apply the pin change for that phase
	function automatic state_t f_enter(state_t s, phase_t p);
		state_t r;
		r = s;
		r.phase = p;
		r.delay_count = 16'd0;
		r.stretch_count = 16'd0;
		case (p)
			PH_ST0: begin
				r.sda_level = 1'b1;
				r.scl_level = 1'b1;
			end
			PH_ST2: r.sda_level = 1'b0;
			PH_ST3: r.scl_level = 1'b0;
			PH_SP0: begin
				r.sda_level = 1'b0;
				r.scl_level = 1'b0;
			end
			PH_SP1: r.scl_level = 1'b1;
			PH_SP3: r.sda_level = 1'b1;
			PH_SB0: begin
				r.sda_level = s.shift_byte[7];
				r.shift_byte = {s.shift_byte[6:0], 1'b0};
			end
			PH_SB1, PH_SA1, PH_RK1: r.scl_level = 1'b1;
			PH_SB3, PH_SA3, PH_RB2: r.scl_level = 1'b0;
			PH_SA0: r.sda_level = 1'b1;
			PH_RB0: begin
				if (s.bit_count == 4'd0)
					r.sda_level = 1'b1;
				r.scl_level = 1'b1;
			end
			// NACK only the final byte
			PH_RK0: r.sda_level = (s.byte_count == s.held_len - 8'd1);
			PH_RK3: begin
				r.scl_level = 1'b0;
				r.sda_level = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic state_t f_send(state_t s, logic [7:0] v);
		state_t r;
		r = s;
		r.shift_byte = v;
		r.bit_count = 4'd0;
		return f_enter(r, PH_SB0);
	endfunction

	// Stage entry; a read of zero bytes goes straight to the stop
	function automatic state_t f_begin(state_t s, stage_t sg, cfg_t c);
		state_t r;
		r = s;
		r.stage = sg;
		case (sg)
			SG_START1, SG_START2: r = f_enter(r, PH_ST0);
			SG_ADDR_W: r = f_send(r, {c.dev_addr, 1'b0});
			SG_REG:    r = f_send(r, s.held_reg);
			SG_ADDR_R: r = f_send(r, {c.dev_addr, 1'b1});
			SG_DATA_W: r = f_send(r, s.held_data);
			SG_READ: begin
				if (s.held_len == 8'd0) begin
					r.stage = SG_STOP;
					r = f_enter(r, PH_SP0);
				end else begin
					r.byte_count = 8'd0;
					r.bit_count = 4'd0;
					r.shift_byte = 8'd0;
					r = f_enter(r, PH_RB0);
				end
			end
			default: begin
				r.stage = SG_STOP;
				r = f_enter(r, PH_SP0);
			end
		endcase
		return r;
	endfunction

	function automatic state_t f_next(state_t s, cfg_t c);
		stage_t sg;
		sg = SG_STOP;
		case (s.stage)
			SG_START1: sg = SG_ADDR_W;
			SG_ADDR_W: sg = SG_REG;
			SG_REG:    sg = s.is_read ? SG_START2 : SG_DATA_W;
			SG_START2: sg = s.is_read ? SG_ADDR_R : SG_STOP;
			SG_ADDR_R: sg = s.is_read ? SG_READ : SG_STOP;
			default:   sg = SG_STOP;
		endcase
		return f_begin(s, sg, c);
	endfunction

	// Timers: SCL-high waits poll with a stretch limit, other phases count delay
	assign is_wait = (st_q.phase == PH_ST0) || (st_q.phase == PH_SP1) ||
	                 (st_q.phase == PH_SB1) || (st_q.phase == PH_SA1) ||
	                 (st_q.phase == PH_RB0) || (st_q.phase == PH_RK1);
	assign dmax     = (cfg.delay_ticks == 16'd0) ? 16'd1 : cfg.delay_ticks;
	assign dcnt_inc = st_q.delay_count + 16'd1;

	// One tick of the sequencer
	always_comb begin
		nxt = st_q;
		finished = 1'b0;
		res = '0;

		if (st_q.phase == PH_IDLE) begin
			if (tick.op == OP_READ || tick.op == OP_WRITE) begin
				nxt.held_reg   = tick.reg_addr;
				nxt.held_data  = tick.write_data;
				nxt.held_len   = tick.read_len;
				nxt.is_read    = (tick.op == OP_READ);
				nxt.error_flag = 1'b0;
				nxt = f_begin(nxt, SG_START1, cfg);
			end
		end else if (is_wait) begin
			if (tick.scl_in || st_q.stretch_count >= cfg.stretch_limit)
				finished = 1'b1;
			else
				nxt.stretch_count = st_q.stretch_count + 16'd1;
		end else begin
			nxt.delay_count = dcnt_inc;
			finished = (dcnt_inc >= dmax);
		end

		if (finished) begin
			case (st_q.phase)
				PH_ST0: nxt = f_enter(nxt, PH_ST1);
				PH_ST1: nxt = f_enter(nxt, PH_ST2);
				PH_ST2: nxt = f_enter(nxt, PH_ST3);
				PH_ST3: nxt = f_next(nxt, cfg);
				PH_SP0: nxt = f_enter(nxt, PH_SP1);
				PH_SP1: nxt = f_enter(nxt, PH_SP2);
				PH_SP2: nxt = f_enter(nxt, PH_SP3);
				PH_SP3: begin
					nxt = f_enter(nxt, PH_IDLE);
					res.done_res = 1'b1;
					res.nack_error = st_q.error_flag;
				end
				PH_SB0: nxt = f_enter(nxt, PH_SB1);
				PH_SB1: nxt = f_enter(nxt, PH_SB2);
				PH_SB2: nxt = f_enter(nxt, PH_SB3);
				PH_SB3: begin
					nxt.bit_count = st_q.bit_count + 4'd1;
					nxt = f_enter(nxt, (nxt.bit_count >= 4'd8) ? PH_SA0 : PH_SB0);
				end
				PH_SA0: nxt = f_enter(nxt, PH_SA1);
				PH_SA1: nxt = f_enter(nxt, PH_SA2);
				PH_SA2: begin
					// Address or register NACK on a read aborts the transfer
					if (st_q.is_read && tick.sda_in)
						nxt.error_flag = 1'b1;
					nxt = f_enter(nxt, PH_SA3);
				end
				PH_SA3: begin
					if (st_q.error_flag)
						nxt = f_begin(nxt, SG_STOP, cfg);
					else
						nxt = f_next(nxt, cfg);
				end
				PH_RB0: nxt = f_enter(nxt, PH_RB1);
				PH_RB1: begin
					nxt.shift_byte = {st_q.shift_byte[6:0], tick.sda_in};
					nxt.bit_count = st_q.bit_count + 4'd1;
					if (nxt.bit_count >= 4'd8) begin
						res.byte_valid = 1'b1;
						res.read_byte = nxt.shift_byte;
						res.last_byte = (st_q.byte_count == st_q.held_len - 8'd1);
					end
					nxt = f_enter(nxt, PH_RB2);
				end
				PH_RB2: nxt = f_enter(nxt, (st_q.bit_count >= 4'd8) ? PH_RK0 : PH_RB0);
				PH_RK0: nxt = f_enter(nxt, PH_RK1);
				PH_RK1: nxt = f_enter(nxt, PH_RK2);
				PH_RK2: nxt = f_enter(nxt, PH_RK3);
				PH_RK3: begin
					nxt.byte_count = st_q.byte_count + 8'd1;
					if (nxt.byte_count == st_q.held_len) begin
						nxt = f_begin(nxt, SG_STOP, cfg);
					end else begin
						nxt.bit_count = 4'd0;
						nxt.shift_byte = 8'd0;
						nxt = f_enter(nxt, PH_RB0);
					end
				end
				default: nxt = f_enter(nxt, PH_IDLE);
			endcase
		end

		res.scl_out  = nxt.scl_level;
		res.sda_out  = nxt.sda_level;
		res.busy_res = (nxt.phase != PH_IDLE);
	end

	// State register, advanced once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= STATE_RST;
		else if (adv)
			st_q <= nxt;
	end

	// A completed stop always lands in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.done_res |=> st_q.phase == PH_IDLE)
		else $error("done without return to idle");

	// A data byte is only produced on the read-bit sampling phase
	a_byte_phase: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.byte_valid |-> st_q.phase == PH_RB1 && st_q.is_read)
		else $error("data byte outside read phase");

	// A command taken while idle starts a start condition
	a_cmd_start: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st_q.phase == PH_IDLE && (tick.op == OP_READ || tick.op == OP_WRITE)
		|=> st_q.phase == PH_ST0 && st_q.stage == SG_START1)
		else $error("command did not start a transfer");

	// An error flag is only reported together with done
	a_nack_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.nack_error |-> res.done_res)
		else $error("nack error without done");

endmodule

// ===== rtl/i2crm_out.sv =====
// i2crm_out: result register between the step logic and the output stream.
// Depends on i2crm_pkg.
`timescale 1ns / 1ps

module i2crm_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  i2crm_pkg::result_t  res,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic                room,
	output i2crm_pkg::result_t  res_out
);
	import i2crm_pkg::*;

	logic    valid_q;
	result_t res_q;

	// A new result may enter when the register is empty or draining this cycle
	assign room = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	// Payload only, no reset needed
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign m_tvalid = valid_q;
	assign res_out  = res_q;

endmodule

// ===== rtl/i2c_register_master_unit.sv =====
// i2c_register_master_unit: top level of the I2C register master.
// Instantiates i2crm_cfg, i2crm_core and i2crm_out; depends on i2crm_pkg.
`timescale 1ns / 1ps

// Every input beat is one bus timing tick with the sampled SCL and SDA levels,
// optionally carrying a read or write command (ignored while busy), and yields
// exactly one result beat with the new line drives and status. The block takes
// one beat per clock; the single result register stalls input only while a result
// waits on m_tready. Bus timing is counted in beats, not clocks: each fixed delay is
// delay_ticks beats and each SCL-high wait polls up to stretch_limit extra beats.
// Configuration is to be written only while idle; the block does not enforce this.
module i2c_register_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// tick stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // reg_addr[7:0], write_data[15:8], read_len[23:16],
	                              // scl_in[24], sda_in[25], zero pad
	input  logic [1:0]  s_tuser,  // op[1:0]
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // scl_out[0], sda_out[1], busy_res[2], read_byte[10:3],
	                              // done_res[11], nack_error[12], zero pad
	output logic        m_tuser,  // byte_valid
	output logic        m_tlast   // last_byte
);
	import i2crm_pkg::*;

	cfg_t    cfg;
	tick_t   tick;
	result_t res;
	result_t res_out;
	logic    room;
	logic    adv;

	// Unpack the input beat
	assign tick.op         = s_tuser;
	assign tick.reg_addr   = s_tdata[7:0];
	assign tick.write_data = s_tdata[15:8];
	assign tick.read_len   = s_tdata[23:16];
	assign tick.scl_in     = s_tdata[24];
	assign tick.sda_in     = s_tdata[25];

	assign s_tready = room;
	assign adv      = s_tvalid && room;

	i2crm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2crm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tick   (tick),
		.cfg    (cfg),
		.res    (res)
	);

	i2crm_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.room     (room),
		.res_out  (res_out)
	);

	// Pack the result beat
	assign m_tdata = {3'b000, res_out.nack_error, res_out.done_res, res_out.read_byte,
	                  res_out.busy_res, res_out.sda_out, res_out.scl_out};
	assign m_tuser = res_out.byte_valid;
	assign m_tlast = res_out.last_byte;

endmodule

// ===== test/tb_i2c_register_master_unit.sv =====
// tb_i2c_register_master_unit: self-checking bench for the I2C register master.
// A directed table, then random read/write traffic, each tick checked against a
// cycle model of the bus sequencer. Depends on i2crm_pkg and i2c_register_master_unit.
`timescale 1ns / 1ps

module tb_i2c_register_master_unit;
	import i2crm_pkg::*;

	// Op code the block must treat as a plain tick
	localparam logic [1:0] OP_SPARE = 2'd3;

	// How the bench answers the send-side acknowledge slots
	localparam logic [1:0] ACK_GOOD = 2'd0;
	localparam logic [1:0] ACK_BAD  = 2'd1;
	localparam logic [1:0] ACK_RAND = 2'd2;

	localparam int HOLD_CYCLES = 300;
	localparam int WD_LIMIT    = 4000;
	localparam int PHASE_TICKS = 40;

	localparam int GAP_PCT   [4] = '{0, 67, 0, 24};
	localparam int STALL_PCT [4] = '{0, 0, 67, 24};

	// Bus released, nothing in progress
	localparam result_t IDLE_R   = '{scl_out: 1'b1, sda_out: 1'b1, default: '0};
	// Command just latched: both lines released, busy
	localparam result_t ACCEPT_R = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
		default: '0};

	typedef struct packed {
		logic        setcfg;
		logic [6:0]  dev;
		logic [15:0] dly;
		logic [15:0] str;
		logic [1:0]  op;
		logic [7:0]  reg_a;
		logic [7:0]  wdat;
		logic [7:0]  rlen;
		logic [1:0]  ack;
		logic [6:0]  scl_low;
		logic        pinned;
		result_t     want;
	} row_t;

	localparam int PLAN_LEN = 12;
	localparam row_t PLAN [PLAN_LEN] = '{
		// idle ticks after reset, plain and with the unused op code
		'{1'b0, 7'd0, 16'd0, 16'd0, OP_TICK, 8'h00, 8'h00, 8'd0, ACK_GOOD, 7'd0, 1'b1, IDLE_R},
		'{1'b0, 7'd0, 16'd0, 16'd0, OP_SPARE, 8'hFF, 8'hFF, 8'hFF, ACK_GOOD, 7'd0, 1'b1, IDLE_R},
		// write at the reset address and stretch limit, shortest delay
		'{1'b1, 7'd21, 16'd1, 16'd500, OP_WRITE, 8'h5A, 8'hC3, 8'd0, ACK_RAND, 7'd0, 1'b1,
			ACCEPT_R},
		// reads: one byte, zero length, address NACK abort
		'{1'b1, 7'd127, 16'd1, 16'd0, OP_READ, 8'hFF, 8'h00, 8'd1, ACK_GOOD, 7'd0, 1'b1, ACCEPT_R},
		'{1'b0, 7'd0, 16'd0, 16'd0, OP_READ, 8'h00, 8'h00, 8'd0, ACK_GOOD, 7'd0, 1'b1, ACCEPT_R},
		'{1'b0, 7'd0, 16'd0, 16'd0, OP_READ, 8'h3C, 8'h00, 8'd3, ACK_BAD, 7'd0, 1'b1, ACCEPT_R},
		// zero delay, a write with NACKs ignored and SCL held low at times
		'{1'b1, 7'd0, 16'd0, 16'd0, OP_WRITE, 8'hFF, 8'hFF, 8'd0, ACK_BAD, 7'd50, 1'b1, ACCEPT_R},
		// clock stretching: the widest limit, then a short limit that runs out
		'{1'b1, 7'd85, 16'd1, 16'hFFFF, OP_READ, 8'h81, 8'h00, 8'd1, ACK_GOOD, 7'd60, 1'b0,
			IDLE_R},
		'{1'b1, 7'd42, 16'd1, 16'd3, OP_READ, 8'h7E, 8'h00, 8'd1, ACK_GOOD, 7'd80, 1'b0, IDLE_R},
		// longest read length, cut off by an address NACK
		'{1'b0, 7'd0, 16'd0, 16'd0, OP_READ, 8'hAA, 8'h00, 8'd255, ACK_BAD, 7'd0, 1'b0, IDLE_R},
		// widest delay register, then widest address and stretch limit; idle only
		'{1'b1, 7'd21, 16'hFFFF, 16'd500, OP_TICK, 8'h00, 8'h00, 8'd0, ACK_GOOD, 7'd0, 1'b1,
			IDLE_R},
		'{1'b1, 7'd127, 16'd1, 16'hFFFF, OP_SPARE, 8'h00, 8'h00, 8'd0, ACK_GOOD, 7'd0, 1'b1,
			IDLE_R}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = CFG_DEV_ADDR;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // reg_addr, write_data, read_len, scl_in, sda_in
	logic [1:0]  s_tuser = OP_TICK;  // op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // scl_out, sda_out, busy_res, read_byte, done_res, nack_error
	logic        m_tuser;  // byte_valid
	logic        m_tlast;  // last_byte

	// Model state and configuration
	phase_t      ph;
	stage_t      stg;
	logic [3:0]  nbits;
	logic [7:0]  nbytes, shreg, hreg, hdata, hlen;
	logic [15:0] dcnt, scnt;
	logic        rd, scl_lv, sda_lv, err;
	logic [6:0]  cfg_dev;
	logic [15:0] cfg_dly, cfg_str;

	result_t response_q [$];
	result_t head, seen;
	int      errors = 0;
	int      quiet = 0;
	int      ticks_sent = 0;
	int      gap_pct = 0;
	int      stall_pct = 0;
	int      scl_low_pct = 0;
	logic [1:0] ack_mode = ACK_GOOD;
	bit      hold_off = 1'b0;

	i2c_register_master_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// ---------------- bus sequencer model ----------------

	function automatic logic final_byte();
		return nbytes == hlen - 8'd1;
	endfunction

	// Enter a phase and apply its pin change
	function automatic void go(phase_t p);
		ph = p;
		dcnt = '0;
		scnt = '0;
		case (p)
			PH_ST0: begin
				sda_lv = 1'b1;
				scl_lv = 1'b1;
			end
			PH_ST2: sda_lv = 1'b0;
			PH_ST3: scl_lv = 1'b0;
			PH_SP0: begin
				sda_lv = 1'b0;
				scl_lv = 1'b0;
			end
			PH_SP1: scl_lv = 1'b1;
			PH_SP3: sda_lv = 1'b1;
			PH_SB0: begin
				sda_lv = shreg[7];
				shreg = shreg << 1;
			end
			PH_SB1, PH_SA1, PH_RK1: scl_lv = 1'b1;
			PH_SB3, PH_SA3, PH_RB2: scl_lv = 1'b0;
			PH_SA0: sda_lv = 1'b1;
			PH_RB0: begin
				if (nbits == 4'd0) sda_lv = 1'b1;
				scl_lv = 1'b1;
			end
			PH_RK0: sda_lv = final_byte();  // NACK the last byte
			PH_RK3: begin
				scl_lv = 1'b0;
				sda_lv = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic void load_byte(logic [7:0] v);
		shreg = v;
		nbits = '0;
		go(PH_SB0);
	endfunction

	function automatic void open_stage(stage_t s);
		stg = s;
		case (s)
			SG_START1, SG_START2: go(PH_ST0);
			SG_ADDR_W: load_byte({cfg_dev, 1'b0});
			SG_REG:    load_byte(hreg);
			SG_ADDR_R: load_byte({cfg_dev, 1'b1});
			SG_DATA_W: load_byte(hdata);
			SG_READ: begin
				if (hlen == 8'd0) begin
					stg = SG_STOP;
					go(PH_SP0);
				end else begin
					nbytes = '0;
					nbits = '0;
					shreg = '0;
					go(PH_RB0);
				end
			end
			default: begin
				stg = SG_STOP;
				go(PH_SP0);
			end
		endcase
	endfunction

	function automatic void advance_stage();
		stage_t nxt;
		nxt = SG_STOP;
		case (stg)
			SG_START1: nxt = SG_ADDR_W;
			SG_ADDR_W: nxt = SG_REG;
			SG_REG:    nxt = rd ? SG_START2 : SG_DATA_W;
			SG_START2: nxt = rd ? SG_ADDR_R : SG_STOP;
			SG_ADDR_R: nxt = rd ? SG_READ : SG_STOP;
			default:   nxt = SG_STOP;
		endcase
		open_stage(nxt);
	endfunction

	// One tick of the sequencer: returns drives and status after the tick
	function automatic result_t bus_response(tick_t t);
		result_t r;
		logic fin, waiting;
		logic [15:0] dmax;
		r = '0;
		fin = 1'b0;
		dmax = (cfg_dly == 16'd0) ? 16'd1 : cfg_dly;
		waiting = ph == PH_ST0 || ph == PH_SP1 || ph == PH_SB1 || ph == PH_SA1 ||
			ph == PH_RB0 || ph == PH_RK1;

		if (ph == PH_IDLE) begin
			if (t.op == OP_READ || t.op == OP_WRITE) begin
				hreg = t.reg_addr;
				hdata = t.write_data;
				hlen = t.read_len;
				rd = t.op == OP_READ;
				err = 1'b0;
				open_stage(SG_START1);
			end
		end else if (waiting) begin
			// SCL-high wait, gives up after the stretch limit
			if (t.scl_in || scnt >= cfg_str) fin = 1'b1;
			else scnt = scnt + 16'd1;
		end else begin
			dcnt = dcnt + 16'd1;
			if (dcnt >= dmax) fin = 1'b1;
		end

		if (fin) begin
			case (ph)
				PH_ST0: go(PH_ST1);
				PH_ST1: go(PH_ST2);
				PH_ST2: go(PH_ST3);
				PH_ST3: advance_stage();
				PH_SP0: go(PH_SP1);
				PH_SP1: go(PH_SP2);
				PH_SP2: go(PH_SP3);
				PH_SP3: begin
					go(PH_IDLE);
					r.done_res = 1'b1;
					r.nack_error = err;
				end
				PH_SB0: go(PH_SB1);
				PH_SB1: go(PH_SB2);
				PH_SB2: go(PH_SB3);
				PH_SB3: begin
					nbits = nbits + 4'd1;
					if (nbits >= 4'd8) go(PH_SA0);
					else go(PH_SB0);
				end
				PH_SA0: go(PH_SA1);
				PH_SA1: go(PH_SA2);
				PH_SA2: begin
					// acknowledges only matter on a read
					if (rd && t.sda_in) err = 1'b1;
					go(PH_SA3);
				end
				PH_SA3: begin
					if (err) open_stage(SG_STOP);
					else advance_stage();
				end
				PH_RB0: go(PH_RB1);
				PH_RB1: begin
					shreg = {shreg[6:0], t.sda_in};
					nbits = nbits + 4'd1;
					if (nbits >= 4'd8) begin
						r.byte_valid = 1'b1;
						r.read_byte = shreg;
						r.last_byte = final_byte();
					end
					go(PH_RB2);
				end
				PH_RB2: begin
					if (nbits >= 4'd8) go(PH_RK0);
					else go(PH_RB0);
				end
				PH_RK0: go(PH_RK1);
				PH_RK1: go(PH_RK2);
				PH_RK2: go(PH_RK3);
				PH_RK3: begin
					nbytes = nbytes + 8'd1;
					if (nbytes == hlen) begin
						open_stage(SG_STOP);
					end else begin
						nbits = '0;
						shreg = '0;
						go(PH_RB0);
					end
				end
				default: go(PH_IDLE);
			endcase
		end

		r.scl_out = scl_lv;
		r.sda_out = sda_lv;
		r.busy_res = ph != PH_IDLE;
		return r;
	endfunction

	task automatic reset_model();
		cfg_dev = DEV_ADDR_RST;
		cfg_dly = DELAY_RST;
		cfg_str = STRETCH_RST;
		ph = PH_IDLE;
		stg = SG_START1;
		nbits = '0;
		nbytes = '0;
		shreg = '0;
		dcnt = '0;
		scnt = '0;
		hreg = '0;
		hdata = '0;
		hlen = '0;
		rd = 1'b0;
		err = 1'b0;
		scl_lv = 1'b1;
		sda_lv = 1'b1;
	endtask

	// ---------------- stimulus ----------------

	// Build a tick; bus levels follow the current ack mode and stretch rate
	function automatic tick_t form_tick(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
		logic [7:0] rl);
		tick_t t;
		t.op = op;
		t.reg_addr = ra;
		t.write_data = wd;
		t.read_len = rl;
		t.scl_in = $urandom_range(99) >= scl_low_pct;
		if ((ph == PH_SA0 || ph == PH_SA1 || ph == PH_SA2 || ph == PH_SA3) &&
			ack_mode != ACK_RAND) begin
			t.sda_in = ack_mode == ACK_BAD;
		end else begin
			t.sda_in = 1'($urandom_range(1));
		end
		return t;
	endfunction

	// Offer one beat; on acceptance, log the expected response
	task automatic send_tick(input tick_t t, input bit pinned, input result_t pinned_r);
		result_t r;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= t.op;
		s_tdata <= {6'd0, t.sda_in, t.scl_in, t.read_len, t.write_data, t.reg_addr};
		do @(posedge clk); while (!s_tready);
		r = bus_response(t);
		response_q.push_back(pinned ? pinned_r : r);
		ticks_sent++;
	endtask

	// Keep ticking until the transaction finishes; commands sent meanwhile are ignored
	task automatic run_to_idle();
		while (ph != PH_IDLE)
			send_tick(form_tick(2'($urandom_range(3)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255))), 1'b0, '0);
	endtask

	// Drain outstanding responses, then write all three registers
	task automatic settle_and_configure(input logic [6:0] dev, input logic [15:0] dly,
		input logic [15:0] str);
		s_tvalid <= 1'b0;
		while (response_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= CFG_DEV_ADDR;
		cfg_wdata <= {9'd0, dev};
		@(posedge clk);
		cfg_index <= CFG_DELAY;
		cfg_wdata <= dly;
		@(posedge clk);
		cfg_index <= CFG_STRETCH;
		cfg_wdata <= str;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cfg_dev = dev;
		cfg_dly = dly;
		cfg_str = str;
	endtask

	// Result sink: random stalls, plus one long hold when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= $urandom_range(99) >= stall_pct;
		end
	end

	// ---------------- checking ----------------

	function automatic void compare(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", what, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (response_q.size() == 0) begin
				$error("response beat with nothing expected");
				errors++;
			end else begin
				head = response_q.pop_front();
				seen = '{m_tdata[0], m_tdata[1], m_tdata[2], m_tuser, m_tdata[10:3], m_tlast,
					m_tdata[11], m_tdata[12]};
				compare("scl_out", 8'(head.scl_out), 8'(seen.scl_out));
				compare("sda_out", 8'(head.sda_out), 8'(seen.sda_out));
				compare("busy_res", 8'(head.busy_res), 8'(seen.busy_res));
				compare("byte_valid", 8'(head.byte_valid), 8'(seen.byte_valid));
				compare("read_byte", head.read_byte, seen.read_byte);
				compare("last_byte", 8'(head.last_byte), 8'(seen.last_byte));
				compare("done_res", 8'(head.done_res), 8'(seen.done_res));
				compare("nack_error", 8'(head.nack_error), 8'(seen.nack_error));
			end
		end
	end

	// Watchdog: too long with no beat moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= WD_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		int start;
		int pick;
		logic [7:0] len;
		logic [1:0] op;

		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (PLAN[i]) begin
			if (PLAN[i].setcfg)
				settle_and_configure(PLAN[i].dev, PLAN[i].dly, PLAN[i].str);
			ack_mode = PLAN[i].ack;
			scl_low_pct = int'(PLAN[i].scl_low);
			send_tick(form_tick(PLAN[i].op, PLAN[i].reg_a, PLAN[i].wdat, PLAN[i].rlen),
				PLAN[i].pinned, PLAN[i].want);
			run_to_idle();
		end

		// random traffic, one idling profile per phase
		for (int p = 0; p < 4; p++) begin
			settle_and_configure(7'($urandom_range(127)), 16'($urandom_range(2)),
				($urandom_range(3) == 0) ? 16'hFFFF :
				($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(40, 1)));
			gap_pct = GAP_PCT[p];
			stall_pct = STALL_PCT[p];
			// back up the output while the sender keeps pushing
			if (p == 0) hold_off = 1'b1;
			start = ticks_sent;
			while (ticks_sent - start < PHASE_TICKS) begin
				pick = $urandom_range(99);
				ack_mode = (pick < 85) ? ACK_GOOD : (pick < 95) ? ACK_BAD : ACK_RAND;
				scl_low_pct = ($urandom_range(99) < 70) ? 0 : int'($urandom_range(40, 1));
				pick = $urandom_range(99);
				if (pick < 8) begin
					// stray tick or unused op while idle
					op = ($urandom_range(1) == 0) ? OP_TICK : OP_SPARE;
					send_tick(form_tick(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255))), 1'b0, '0);
				end else begin
					op = ($urandom_range(1) == 0) ? OP_READ : OP_WRITE;
					pick = $urandom_range(99);
					if (pick < 85) len = 8'($urandom_range(4));
					else len = 8'($urandom_range(8, 5));
					send_tick(form_tick(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
						len), 1'b0, '0);
					run_to_idle();
				end
			end
		end

		s_tvalid <= 1'b0;
		while (response_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
